// ----- rtl/hdbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hdbp_pkg: shared types and constants for the height map disc brush painter
// Command and result words, queue job word, codes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package hdbp_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEF_GRID_SIZE  = 256;
  localparam int DEF_MAX_RADIUS = 50;

  // Fixed widths
  localparam int POS_W      = 8;   // coordinate fields of the command word
  localparam int HGT_W      = 16;  // unsigned 8.8 height
  localparam int RAD_W      = 7;   // effective radius, clamped to MAX_RADIUS
  localparam int OFS_W      = 8;   // signed walk offset
  localparam int COORD_W    = 14;  // signed cell coordinate during the walk
  localparam int D2_W       = 14;  // squared distance
  localparam int CNT_W      = 14;  // count of walked cells on the grid
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HGT_W-1:0] HEIGHT_MAX = 16'hFF00;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 14'h3FFF;

  // Register reset values
  localparam logic [5:0] RADIUS_RST = 6'd10;
  localparam logic [7:0] POWER_RST  = 8'd128;
  localparam logic       RAISE_RST  = 1'b1;

  typedef enum logic {
    OP_PAINT = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_POWER  = 2'd1,
    CFG_RAISE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_READ_WAIT
  } back_state_t;

  // Command word
  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [HGT_W-1:0] step_amount;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic [7:0]       height_value;
    logic [CNT_W-1:0] cells_changed;
  } rsp_t;

  // Classified job held in the queue
  typedef struct packed {
    logic             is_read;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [HGT_W-1:0] step;
    logic [RAD_W-1:0] radius;
    logic             raising;
  } job_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/heightmap_disc_brush_paint.sv -----
// ----------------------------------------------------------------------------
// heightmap_disc_brush_paint: disc brush painter over a square height map
// Front end classifies command words, a two entry queue holds them, and the
// back end walks the brush over the height store one cell per cycle.
// ----------------------------------------------------------------------------
//  channel   handshake               word
//  command   start && !busy          cmd (operation, pos_x, pos_y, step_amount)
//  result    result_valid, 1 cycle   result (height_value, cells_changed)
//  config    cfg_valid && cfg_ready  cfg_index, cfg_data
//
//  A read's result is taken from the store in the read wait state; a paint of
//  effective radius r is paced by the one-cell-per-cycle walk on the store's
//  single write port. Items are carried out one at a time in order.
//  After reset the store is cleared with busy high; config writes are taken.
//  busy also rises when the queue holds two words; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_disc_brush_paint import hdbp_pkg::*; #(
  parameter int GRID_SIZE  = DEF_GRID_SIZE,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cmd_t                  cmd,
  output logic                       result_valid,
  output rsp_t                       result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  back_status_t bstat;
  logic         q_full;
  logic         push;
  job_t         push_job;
  logic         pop;
  logic         head_valid;
  job_t         head;

  // Intake and classification
  hdbp_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bstat     (bstat),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  // Job queue
  hdbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Store and walk engine
  hdbp_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .bstat        (bstat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- rtl/hdbp_front.sv -----
// ----------------------------------------------------------------------------
// hdbp_front: command intake and classification
// Holds the brush registers, accepts command words and turns them into jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module hdbp_front import hdbp_pkg::*; #(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cmd_t                  cmd,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire back_status_t          bstat,
  input  wire logic                  q_full,
  output logic                       push,
  output job_t                       job
);

  logic [5:0] brush_radius;
  logic [7:0] brush_power;
  logic       raise_mode;
  logic [RAD_W-1:0] radius_ext;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius <= RADIUS_RST;
      brush_power  <= POWER_RST;
      raise_mode   <= RAISE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_RADIUS: brush_radius <= cfg_data[5:0];
        CFG_POWER:  brush_power  <= cfg_data;
        CFG_RAISE:  raise_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Intake: stall while the store is being cleared or the queue is full
  assign busy = bstat.clearing || q_full;
  assign push = start && !busy;

  // Classification
  assign radius_ext = {{(RAD_W-6){1'b0}}, brush_radius};

  always_comb begin
    job.is_read = (op_e'(cmd.operation) == OP_READ);
    job.pos_x   = cmd.pos_x;
    job.pos_y   = cmd.pos_y;
    job.step    = cmd.step_amount;
    job.radius  = (radius_ext > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ext;
    job.raising = raise_mode && (brush_power != 8'd0);
  end

endmodule

`default_nettype wire

// ----- rtl/hdbp_queue.sv -----
// ----------------------------------------------------------------------------
// hdbp_queue: short job queue between front and back
// Two entry first-in first-out buffer of job words.
// ----------------------------------------------------------------------------
`default_nettype none

module hdbp_queue import hdbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full       = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (!push && pop) fill <= fill - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

// ----- rtl/hdbp_back.sv -----
// ----------------------------------------------------------------------------
// hdbp_back: height store and brush walk engine
// Clears the store after reset, walks paint jobs one cell a cycle with a
// pipelined read-modify-write, and answers cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module hdbp_back import hdbp_pkg::*; #(
  parameter int GRID_SIZE = DEF_GRID_SIZE
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire job_t   head,
  output logic        pop,
  output back_status_t bstat,
  output logic        result_valid,
  output rsp_t        result
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  back_state_t state, state_next;

  logic [HGT_W-1:0] mem [DEPTH];
  logic [HGT_W-1:0] rd_data;

  logic [AW-1:0]           clr_addr;
  logic signed [OFS_W-1:0] dr;
  logic signed [OFS_W-1:0] dc;
  logic [D2_W-1:0]         r2;
  logic [CNT_W-1:0]        count;
  logic                    rd_ok;
  logic                    p_valid;
  logic [AW-1:0]           p_addr;
  logic                    p_up;

  logic signed [OFS_W-1:0]   r_ofs;
  logic signed [OFS_W-1:0]   neg_r;
  logic signed [OFS_W-1:0]   r_m1;
  logic signed [COORD_W-1:0] row;
  logic signed [COORD_W-1:0] col;
  logic                      cell_ok;
  logic [AW-1:0]             cell_addr;
  logic [COORD_W-1:0]        px_ext;
  logic [COORD_W-1:0]        py_ext;
  logic                      rd_pos_ok;
  logic [AW-1:0]             read_addr;
  logic [AW-1:0]             rd_addr_c;
  logic signed [2*OFS_W-1:0] dr_sq;
  logic signed [2*OFS_W-1:0] dc_sq;
  logic [D2_W-1:0]           d2;
  logic                      up_c;
  logic [D2_W-1:0]           r_wide;
  logic [HGT_W:0]            sum;
  logic [HGT_W-1:0]          new_h;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [HGT_W-1:0]          wd;

  // Walk bounds
  assign r_ofs  = $signed({{(OFS_W-RAD_W){1'b0}}, head.radius});
  assign neg_r  = -r_ofs;
  assign r_m1   = r_ofs - OFS_W'(1);
  assign r_wide = {{(D2_W-RAD_W){1'b0}}, head.radius};

  // Current cell of the walk
  assign px_ext = {{(COORD_W-POS_W){1'b0}}, head.pos_x};
  assign py_ext = {{(COORD_W-POS_W){1'b0}}, head.pos_y};
  assign row = $signed(px_ext) + $signed({{(COORD_W-OFS_W){dr[OFS_W-1]}}, dr});
  assign col = $signed(py_ext) + $signed({{(COORD_W-OFS_W){dc[OFS_W-1]}}, dc});
  assign cell_ok = !row[COORD_W-1] && ($unsigned(row) < COORD_W'(GRID_SIZE)) &&
                   !col[COORD_W-1] && ($unsigned(col) < COORD_W'(GRID_SIZE));
  assign cell_addr = {row[CW-1:0], col[CW-1:0]};

  // Disc test
  assign dr_sq = dr * dr;
  assign dc_sq = dc * dc;
  assign d2    = dr_sq[D2_W-1:0] + dc_sq[D2_W-1:0];
  assign up_c  = head.raising && (d2 < r2);

  // Cell read address
  assign rd_pos_ok = (px_ext < COORD_W'(GRID_SIZE)) && (py_ext < COORD_W'(GRID_SIZE));
  assign read_addr = {px_ext[CW-1:0], py_ext[CW-1:0]};
  assign rd_addr_c = (state == ST_IDLE) ? read_addr : cell_addr;

  // Saturating step of the height read back
  assign sum = {1'b0, rd_data} + {1'b0, head.step};
  always_comb begin
    if (p_up) begin
      new_h = (sum > {1'b0, HEIGHT_MAX}) ? HEIGHT_MAX : sum[HGT_W-1:0];
    end else begin
      new_h = (rd_data > head.step) ? (rd_data - head.step) : '0;
    end
  end

  // Write port: clearing pass or write-back stage
  assign we = (state == ST_CLEAR) || p_valid;
  assign wa = (state == ST_CLEAR) ? clr_addr : p_addr;
  assign wd = (state == ST_CLEAR) ? '0 : new_h;

  // Height store
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr_c];
    if (we) mem[wa] <= wd;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and queue pop
  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    bstat.clearing = (state == ST_CLEAR);
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid) begin
          if (head.is_read)             state_next = ST_READ_WAIT;
          else if (head.radius == '0)   state_next = ST_DRAIN;
          else                          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if ((dc == r_m1) && (dr == r_m1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        pop        = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ_WAIT: begin
        pop        = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Clear pass, walk control and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      p_valid      <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_DRAIN) || (state == ST_READ_WAIT);
      p_valid      <= (state == ST_WALK) && cell_ok;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if ((state == ST_IDLE) && head_valid) begin
        count <= '0;
      end else if ((state == ST_WALK) && cell_ok && (count != COUNT_MAX)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Walk datapath and result word
  always_ff @(posedge clk) begin
    p_addr <= cell_addr;
    p_up   <= up_c;
    if ((state == ST_IDLE) && head_valid) begin
      dr    <= neg_r;
      dc    <= neg_r;
      r2    <= r_wide * r_wide;
      rd_ok <= rd_pos_ok;
    end else if (state == ST_WALK) begin
      if (dc == r_m1) begin
        dc <= neg_r;
        dr <= dr + OFS_W'(1);
      end else begin
        dc <= dc + OFS_W'(1);
      end
    end
    if (state == ST_DRAIN) begin
      result.height_value  <= '0;
      result.cells_changed <= count;
    end else begin
      result.height_value  <= rd_ok ? rd_data[HGT_W-1:8] : '0;
      result.cells_changed <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hdbp_checker.sv -----
// ----------------------------------------------------------------------------
// hdbp_checker: port level checks for the disc brush painter
// Watches the result channel and the reset behavior at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module hdbp_checker import hdbp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic result_valid,
  input wire rsp_t result
);

  // Result strobes never come in adjacent cycles
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobes in two adjacent cycles");

  // A word carries either a height or a count, never both
  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.height_value != 8'd0)) |-> (result.cells_changed == '0))
    else $error("result word carries both height and count");

  // The store clearing pass holds off commands right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("not busy right after reset");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result strobe right after reset");

endmodule

bind heightmap_disc_brush_paint hdbp_checker u_hdbp_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

// ----- bench/heightmap_paint_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_paint_checker: result checker for the disc brush painter
// Watches the command, config and result channels, keeps its own copy of the
// height map and brush registers, predicts one result word per command and
// compares each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module heightmap_paint_checker import hdbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  cmd_t                  cmd,
  input  logic                  result_valid,
  input  rsp_t                  result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    n_errors,
  output int                    n_pending,
  output int                    n_checked
);

  localparam int CELLS      = DEF_GRID_SIZE * DEF_GRID_SIZE;
  localparam int PRINT_CAP  = 40;

  // Shadow height map and brush registers
  logic [HGT_W-1:0] hmap [0:CELLS-1];
  logic [5:0]       radius_r;
  logic [7:0]       power_r;
  logic             raise_r;

  // Predicted result words, oldest first
  rsp_t expected_q[$];
  rsp_t want;
  rsp_t got;
  cmd_t seen;

  initial begin
    n_errors  = 0;
    n_pending = 0;
    n_checked = 0;
  end

  task automatic flag_mismatch(input string msg);
    if (n_errors < PRINT_CAP)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Height after one step, clipped to 0.0 .. 255.0
  function automatic logic [HGT_W-1:0] stepped_height(input logic [HGT_W-1:0] h,
                                                       input logic [HGT_W-1:0] amount,
                                                       input logic up);
    logic [HGT_W:0] sum;
    if (up) begin
      sum = h + amount;
      return (sum > HEIGHT_MAX) ? HEIGHT_MAX : sum[HGT_W-1:0];
    end
    return (h > amount) ? h - amount : '0;
  endfunction

  // Apply one brush stroke to the shadow map, return the visited cell count
  function automatic logic [CNT_W-1:0] stroke_disc(input cmd_t c);
    int r;
    int r2;
    int cx;
    int cy;
    int row;
    int col;
    int dx;
    int dy;
    int idx;
    logic raising;
    logic [CNT_W-1:0] cnt;
    r = radius_r;
    if (r > DEF_MAX_RADIUS)
      r = DEF_MAX_RADIUS;
    r2 = r * r;
    cx = c.pos_x;
    cy = c.pos_y;
    raising = raise_r && (power_r != 0);
    cnt = '0;
    for (dx = -r; dx < r; dx++) begin
      row = cx + dx;
      if (row < 0 || row >= DEF_GRID_SIZE)
        continue;
      for (dy = -r; dy < r; dy++) begin
        col = cy + dy;
        if (col < 0 || col >= DEF_GRID_SIZE)
          continue;
        idx = row * DEF_GRID_SIZE + col;
        hmap[idx] = stepped_height(hmap[idx], c.step_amount,
                                   raising && (dx * dx + dy * dy < r2));
        if (cnt < COUNT_MAX)
          cnt++;
      end
    end
    return cnt;
  endfunction

  // Integer part of one cell; zero off the grid
  function automatic logic [7:0] cell_height(input cmd_t c);
    int cx;
    int cy;
    cx = c.pos_x;
    cy = c.pos_y;
    if (cx < DEF_GRID_SIZE && cy < DEF_GRID_SIZE)
      return hmap[cx * DEF_GRID_SIZE + cy][HGT_W-1:8];
    return '0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++)
        hmap[i] = '0;
      radius_r = RADIUS_RST;
      power_r  = POWER_RST;
      raise_r  = RAISE_RST;
      expected_q.delete();
      n_pending = 0;
    end else begin
      // Result word against the oldest prediction
      if (result_valid) begin
        got = result;
        n_checked++;
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word h=%0d n=%0d",
                                  got.height_value, got.cells_changed));
        end else begin
          want = expected_q.pop_front();
          if (got.height_value !== want.height_value)
            flag_mismatch($sformatf("height_value %0d, expected %0d",
                                    got.height_value, want.height_value));
          if (got.cells_changed !== want.cells_changed)
            flag_mismatch($sformatf("cells_changed %0d, expected %0d",
                                    got.cells_changed, want.cells_changed));
        end
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_RADIUS: radius_r = cfg_data[5:0];
          CFG_POWER:  power_r  = cfg_data[7:0];
          CFG_RAISE:  raise_r  = cfg_data[0];
          default: ;
        endcase
      end

      // Accepted command word
      if (start && !busy) begin
        seen = cmd;
        want = '0;
        if (seen.operation == OP_READ)
          want.height_value = cell_height(seen);
        else
          want.cells_changed = stroke_disc(seen);
        expected_q.push_back(want);
      end

      n_pending = expected_q.size();
    end
  end

endmodule

// ----- bench/tb_heightmap_disc_brush_paint.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_disc_brush_paint: testbench top for the disc brush painter
// Drives a directed set of strokes and reads (grid corners, saturation,
// radius zero and oversize, power zero, lowering mode), then random phases
// of strokes and reads with fresh brush settings per phase. Checking is done
// by the checker instance; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_heightmap_disc_brush_paint;
  import hdbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 80;
  localparam int DRAIN_LIMIT  = 40000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  cmd_t                  cmd;
  logic                  result_valid;
  rsp_t                  result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int n_errors;
  int n_pending;
  int n_checked;
  int n_paints;
  int n_reads;
  int n_writes;
  int gap_max;
  int last_x;
  int last_y;
  int last_r;
  int n_rand;
  int burst;

  heightmap_disc_brush_paint u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  heightmap_paint_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .n_errors     (n_errors),
    .n_pending    (n_pending),
    .n_checked    (n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: store clear plus every word at full radius, several times over
  initial begin
    #48_000_000;
    $display("Timeout with %0d words outstanding", n_pending);
    $display("Test completed with failures");
    $finish;
  end

  // Random hold-off before the next word
  task automatic pause_sender();
    int g;
    g = $urandom_range(gap_max, 0);
    if (g > 0) begin
      start = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    pause_sender();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_writes++;
  endtask

  // Present one command word and hold it until taken; start stays high
  task automatic issue(input op_e op, input int x, input int y, input logic [15:0] amount);
    cmd_t w;
    w.operation   = op;
    w.pos_x       = 8'(x);
    w.pos_y       = 8'(y);
    w.step_amount = amount;
    pause_sender();
    start = 1'b1;
    cmd   = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (op == OP_READ) begin
      n_reads++;
    end else begin
      n_paints++;
      last_x = x;
      last_y = y;
    end
  endtask

  // Drain all outstanding words, then let the back end go quiet
  task automatic settle();
    int waited;
    start = 1'b0;
    waited = 0;
    while (n_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (16) @(negedge clk);
  endtask

  function automatic int clip_coord(input int v);
    if (v < 0)
      return 0;
    if (v > 255)
      return 255;
    return v;
  endfunction

  // One phase: new brush settings, then a burst of strokes and reads
  task automatic random_phase(input int count);
    int r;
    int x;
    int y;
    logic [15:0] amount;
    settle();
    gap_max = ($urandom_range(3, 0) == 0) ? 0 : 4;
    if ($urandom_range(7, 0) == 0)
      r = $urandom_range(63, 40);
    else
      r = $urandom_range(7, 0);
    last_r = (r > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : r;
    write_reg(CFG_RADIUS, {2'($urandom_range(3, 0)), 6'(r)});
    write_reg(CFG_POWER, ($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
    write_reg(CFG_RAISE, 8'($urandom));
    if ($urandom_range(5, 0) == 0)
      write_reg(CFG_SPARE, 8'($urandom));
    for (int k = 0; k < count; k++) begin
      amount = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(1023, 0));
      if ($urandom_range(9, 0) < 6) begin
        // strokes hug the edges now and then so the walk gets clipped
        if ($urandom_range(3, 0) == 0) begin
          x = $urandom_range(1, 0) ? $urandom_range(3, 0) : $urandom_range(255, 252);
          y = $urandom_range(255, 0);
        end else begin
          x = $urandom_range(255, 0);
          y = $urandom_range(255, 0);
        end
        issue(OP_PAINT, x, y, amount);
      end else if ($urandom_range(9, 0) < 7) begin
        // read near the last stroke so painted cells come back
        x = clip_coord(last_x + $urandom_range(2 * last_r + 1, 0) - last_r);
        y = clip_coord(last_y + $urandom_range(2 * last_r + 1, 0) - last_r);
        issue(OP_READ, x, y, amount);
      end else begin
        issue(OP_READ, $urandom_range(255, 0), $urandom_range(255, 0), amount);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_data  = '0;
    gap_max   = 2;
    n_paints  = 0;
    n_reads   = 0;
    n_writes  = 0;
    last_x    = 128;
    last_y    = 128;
    last_r    = 10;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset brush: disc at the center, corner lowering, saturation at the corners
    issue(OP_PAINT, 128, 128, 16'h0100);
    issue(OP_READ, 128, 128, 16'h0000);
    issue(OP_READ, 137, 128, 16'hFFFF);
    issue(OP_READ, 118, 118, 16'h0000);
    issue(OP_PAINT, 0, 0, 16'hFFFF);
    issue(OP_READ, 0, 0, 16'h0000);
    issue(OP_PAINT, 255, 255, 16'hFFFF);
    issue(OP_READ, 255, 255, 16'h0000);
    issue(OP_READ, 254, 0, 16'h0000);

    // Oversize radius saturates, power zero forces lowering
    settle();
    write_reg(CFG_RADIUS, 8'hFF);
    write_reg(CFG_POWER, 8'd0);
    write_reg(CFG_RAISE, 8'd1);
    issue(OP_PAINT, 0, 0, 16'h0080);
    issue(OP_PAINT, 128, 128, 16'hFFFF);
    issue(OP_READ, 0, 0, 16'h0000);
    issue(OP_READ, 128, 128, 16'h0000);

    // Radius zero: empty walk
    settle();
    write_reg(CFG_RADIUS, 8'd0);
    issue(OP_PAINT, 10, 10, 16'h0500);
    issue(OP_READ, 10, 10, 16'h0000);

    // Largest radius in lowering mode at an off-center corner
    settle();
    gap_max = 0;
    write_reg(CFG_RADIUS, 8'd50);
    write_reg(CFG_POWER, 8'd255);
    write_reg(CFG_RAISE, 8'd0);
    issue(OP_PAINT, 255, 0, 16'h0001);
    issue(OP_READ, 255, 0, 16'h0000);

    // Smallest disc: one raised cell, three lowered; spare index is ignored
    settle();
    gap_max = 4;
    write_reg(CFG_RADIUS, 8'd1);
    write_reg(CFG_POWER, 8'd1);
    write_reg(CFG_RAISE, 8'hFF);
    write_reg(CFG_SPARE, 8'hA5);
    issue(OP_PAINT, 200, 100, 16'h0A00);
    issue(OP_READ, 200, 100, 16'h0000);
    issue(OP_READ, 199, 99, 16'h0000);
    issue(OP_PAINT, 255, 255, 16'h0300);
    issue(OP_READ, 255, 255, 16'h0000);

    // Random phases
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      burst = $urandom_range(12, 8);
      random_phase(burst);
      n_rand += burst;
    end

    settle();
    $display("Sent %0d strokes and %0d reads with %0d register writes;",
             n_paints, n_reads, n_writes);
    $display("checked %0d result words, %0d mismatches", n_checked, n_errors);
    if (n_pending != 0)
      $display("%0d predicted result words never arrived", n_pending);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hdbp_pkg.sv
rtl/hdbp_front.sv
rtl/hdbp_queue.sv
rtl/hdbp_back.sv
rtl/heightmap_disc_brush_paint.sv
rtl/hdbp_checker.sv
bench/heightmap_paint_checker.sv
bench/tb_heightmap_disc_brush_paint.sv
